>>> design/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_COUNT_DEF = 16;

    localparam int PAGE_IN_W = 4;
    localparam int FRAME_CNT_W = 4;
    localparam int FAULT_W = 32;

    localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_RST = 4'd3;

    // per-cell command, decoded once per word by the top level
    typedef struct packed {
        logic en;         // a word is accepted this cycle
        logic hit;        // page already resident somewhere in the row
        logic evict;      // miss with a full row, drop the head cell
        logic in_use;     // cell holds a resident page
        logic below_top;  // cell is not the newest occupied one
        logic tail;       // cell takes the referenced page
    } t_cell_ctl;

    // reduce a page reference into the page range; at most eight steps
    function automatic logic [PAGE_IN_W-1:0] page_mod(
        input logic [PAGE_IN_W-1:0] v,
        input int unsigned          pc
    );
        int unsigned acc;
        acc = int'(v);
        for (int s = 0; s < 8; s++) begin
            if (acc >= pc) begin
                acc = acc - pc;
            end
        end
        return PAGE_IN_W'(acc);
    endfunction

endpackage

`default_nettype wire

>>> design/lrupr_cell.sv
`default_nettype none

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int PAGE_W = 4
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [PAGE_W-1:0] i_page,
    input  wire logic [PAGE_W-1:0] i_next_page,
    input  wire logic              i_seen,
    output logic [PAGE_W-1:0]      o_page,
    output logic                   o_match,
    output logic                   o_seen
);

    logic [PAGE_W-1:0] r_page;
    logic              w_shift;
    logic              w_load;

    assign o_page  = r_page;
    assign o_match = i_ctl.in_use && (r_page == i_page);
    // seen: the hit position is at or below this cell
    assign o_seen  = i_seen | o_match;

    assign w_shift = i_ctl.en & i_ctl.below_top & (i_ctl.evict | (i_ctl.hit & o_seen));
    assign w_load  = i_ctl.en & i_ctl.tail;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_page <= i_page;
        end else if (w_shift) begin
            r_page <= i_next_page;
        end
    end

endmodule

`default_nettype wire

>>> design/lru_page_replacement_core.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  -----------------------------------------
// input     in         i_valid / o_stall       i_page_number
// output    out        o_valid / i_stall       o_fault, o_evicted_valid,
//                                              o_evicted_page, o_fault_total
// config    in         i_cfg_we                i_cfg_data (frame_count)
//
// The associative compare and shift over the cell row happen in the cycle the word
// is accepted, and the result lands in the output register.
// A new word is taken whenever the output register is empty or is being drained.
// Reset clears occupancy, the fault count and the output valid, and sets frame
// count to 3. Cell contents are not reset; unoccupied cells are never compared.
// A stalled result holds in the output register and blocks further input words.

module lru_page_replacement_core
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [FRAME_CNT_W-1:0] i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [PAGE_IN_W-1:0]   i_page_number,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_fault,
    output logic                        o_evicted_valid,
    output logic [PAGE_IN_W-1:0]        o_evicted_page,
    output logic [FAULT_W-1:0]          o_fault_total
);

    localparam int PAGE_W = $clog2(PAGE_COUNT);
    localparam int OCC_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (OCC_W > FRAME_CNT_W) ? OCC_W : FRAME_CNT_W;
    localparam logic [OCC_W-1:0]   OCC_FULL  = OCC_W'(MAX_FRAMES);
    localparam logic [FAULT_W-1:0] FAULT_SAT = '1;

    // control and configuration
    logic [FRAME_CNT_W-1:0] r_frame_count;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [FAULT_W-1:0]     r_fault_cnt, n_fault_cnt;
    logic                   r_out_valid, n_out_valid;

    // output payload
    logic                   r_fault;
    logic                   r_ev_valid;
    logic [PAGE_IN_W-1:0]   r_ev_page;
    logic [FAULT_W-1:0]     r_total;

    logic                   w_accept;
    logic [PAGE_IN_W-1:0]   w_pg_red;
    logic [PAGE_W+PAGE_IN_W-1:0] w_pg_ext;
    logic [PAGE_W-1:0]      w_page_in;
    logic [PAGE_W+PAGE_IN_W-1:0] w_ev_ext;

    logic [MAX_FRAMES-1:0]  w_match;
    logic [MAX_FRAMES:0]    w_seen;
    logic [PAGE_W-1:0]      w_page [MAX_FRAMES];
    logic [PAGE_W-1:0]      w_next [MAX_FRAMES];
    t_cell_ctl              w_ctl  [MAX_FRAMES];

    logic                   w_hit;
    logic                   w_evict;
    logic [OCC_W-1:0]       w_tail;
    logic [CMP_W-1:0]       w_occ_cmp;
    logic [CMP_W-1:0]       w_fc_cmp;

    // handshake: a pending result only blocks input while it is stalled
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // fold the reference into the page range, then size it for the cells
    assign w_pg_red  = page_mod(i_page_number, PAGE_COUNT);
    assign w_pg_ext  = {{PAGE_W{1'b0}}, w_pg_red};
    assign w_page_in = w_pg_ext[PAGE_W-1:0];

    // pages are unique in the row, so any match is the hit
    assign w_hit = |w_match;

    // on a miss, evict when the row is at or above the frame count; a frame count of zero
    // behaves as one, and one above the capacity is capped by the full check
    assign w_occ_cmp = CMP_W'(r_occ);
    assign w_fc_cmp  = CMP_W'(r_frame_count);
    assign w_evict   = ~w_hit && (r_occ != '0) &&
                       ((w_occ_cmp >= w_fc_cmp) || (r_occ == OCC_FULL));

    // newest page goes into the top occupied cell after a shift, else one above
    assign w_tail = (w_hit | w_evict) ? (r_occ - OCC_W'(1)) : r_occ;

    assign w_seen[0] = 1'b0;

    for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
        localparam logic [OCC_W-1:0] K_IDX  = OCC_W'(k);
        localparam logic [OCC_W-1:0] K_NEXT = OCC_W'(k + 1);

        always_comb begin
            w_ctl[k].en        = w_accept;
            w_ctl[k].hit       = w_hit;
            w_ctl[k].evict     = w_evict;
            w_ctl[k].in_use    = K_IDX < r_occ;
            w_ctl[k].below_top = K_NEXT < r_occ;
            w_ctl[k].tail      = (w_tail == K_IDX);
        end

        // the top cell never shifts; feed it the new page to keep it tied off
        if (k == MAX_FRAMES - 1) begin : g_top
            assign w_next[k] = w_page_in;
        end else begin : g_mid
            assign w_next[k] = w_page[k+1];
        end

        lrupr_cell #(
            .PAGE_W (PAGE_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[k]),
            .i_page      (w_page_in),
            .i_next_page (w_next[k]),
            .i_seen      (w_seen[k]),
            .o_page      (w_page[k]),
            .o_match     (w_match[k]),
            .o_seen      (w_seen[k+1])
        );
    end

    // head cell holds the least recently used page
    assign w_ev_ext = {{PAGE_IN_W{1'b0}}, w_page[0]};

    always_comb begin
        n_occ       = r_occ;
        n_fault_cnt = r_fault_cnt;
        n_out_valid = r_out_valid & i_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (~w_hit) begin
                if (r_fault_cnt != FAULT_SAT) begin
                    n_fault_cnt = r_fault_cnt + FAULT_W'(1);
                end
                // grow only when nothing is evicted
                if (~w_evict) begin
                    n_occ = r_occ + OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_CNT_RST;
            r_occ         <= '0;
            r_fault_cnt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
            r_occ       <= n_occ;
            r_fault_cnt <= n_fault_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // load the result with the word; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fault    <= ~w_hit;
            r_ev_valid <= w_evict;
            r_ev_page  <= w_evict ? w_ev_ext[PAGE_IN_W-1:0] : '0;
            r_total    <= n_fault_cnt;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_fault         = r_fault;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_total;

endmodule

`default_nettype wire

>>> dv/tb_lru_page_replacement_core.sv
`default_nettype none

module tb_lru_page_replacement_core
    import lrupr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAMES = MAX_FRAMES_DEF;
    localparam int PAGE_COUNT = PAGE_COUNT_DEF;

    // One result word as the block reports it.
    typedef struct packed {
        logic                 fault;
        logic                 evicted_valid;
        logic [PAGE_IN_W-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_total;
    } t_lru_result;

    // Clock, reset and every input start at known values.
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [FRAME_CNT_W-1:0] i_cfg_data      = '0;
    logic                   i_valid         = 1'b0;
    logic [PAGE_IN_W-1:0]   i_page_number   = '0;
    logic                   i_stall         = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_fault;
    logic                   o_evicted_valid;
    logic [PAGE_IN_W-1:0]   o_evicted_page;
    logic [FAULT_W-1:0]     o_fault_total;

    // Page references waiting to be sent, and results owed by the block.
    logic [PAGE_IN_W-1:0] pending_pages[$];
    t_lru_result          expected_results[$];

    // Shadow copy of the replacement state.
    logic [PAGE_IN_W-1:0]   lru_pages[MAX_FRAMES];
    int                     resident_cnt = 0;
    bit                     page_resident[PAGE_COUNT];
    logic [FAULT_W-1:0]     faults_seen = '0;
    logic [FRAME_CNT_W-1:0] frame_reg = FRAME_CNT_RST;

    int mismatches = 0;
    bit quiet_phase = 1'b0;   // no gaps on either side while set

    always #2 i_clk = ~i_clk;

    lru_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_COUNT (PAGE_COUNT)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_fault         (o_fault),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    // Advance the shadow state by one reference and queue the result it owes.
    function automatic void apply_reference(input logic [PAGE_IN_W-1:0] ref_page);
        t_lru_result res;
        int          slot;
        int          pos;
        int          frames;
        slot   = int'(ref_page) % PAGE_COUNT;
        frames = int'(frame_reg);
        // clamp the frame count into 1..MAX_FRAMES
        if (frames < 1) begin
            frames = 1;
        end
        if (frames > MAX_FRAMES) begin
            frames = MAX_FRAMES;
        end
        res = '0;
        if (page_resident[slot]) begin
            // hit: move the page to the newest end
            pos = resident_cnt;
            for (int k = 0; k < resident_cnt; k++) begin
                if (lru_pages[k] == PAGE_IN_W'(slot) && pos == resident_cnt) begin
                    pos = k;
                end
            end
            if (pos < resident_cnt) begin
                for (int k = pos; k + 1 < resident_cnt; k++) begin
                    lru_pages[k] = lru_pages[k+1];
                end
                lru_pages[resident_cnt-1] = PAGE_IN_W'(slot);
            end
        end else begin
            res.fault = 1'b1;
            if (faults_seen != '1) begin
                faults_seen = faults_seen + 1'b1;
            end
            // drop the oldest page when the row is full; a lowered frame count
            // drops only one, so occupancy stays where it was
            if (resident_cnt >= frames && resident_cnt > 0) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = lru_pages[0];
                page_resident[int'(lru_pages[0]) % PAGE_COUNT] = 1'b0;
                for (int k = 0; k + 1 < resident_cnt; k++) begin
                    lru_pages[k] = lru_pages[k+1];
                end
                resident_cnt--;
            end
            if (resident_cnt < MAX_FRAMES) begin
                lru_pages[resident_cnt] = PAGE_IN_W'(slot);
                resident_cnt++;
                page_resident[slot] = 1'b1;
            end
        end
        res.fault_total = faults_seen;
        expected_results.push_back(res);
    endfunction

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Driver: take a word off the queue, hold it until accepted, idle for a random gap between words.
    always @(posedge i_clk) begin : drive_pages
        int  send_gap;
        bit  word_taken;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_page_number <= '0;
            send_gap = 0;
        end else begin
            word_taken = i_valid && !o_stall;
            if (word_taken) begin
                apply_reference(i_page_number);
                void'(pending_pages.pop_front());
            end
            if (i_valid && !word_taken) begin
                // hold the stalled word as it is
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_pages.size() > 0) begin
                i_valid       <= 1'b1;
                i_page_number <= pending_pages[0];
                send_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation,
    // and stall the output at random.
    always @(posedge i_clk) begin : watch_results
        int          stall_left;
        t_lru_result got;
        t_lru_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_fault, o_evicted_valid, o_evicted_page, o_fault_total};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: fault=%0b ev=%0b page=%0d total=%0d",
                                 got.fault, got.evicted_valid, got.evicted_page,
                                 got.fault_total);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: exp fault=%0b ev=%0b page=%0d total=%0d",
                                     want.fault, want.evicted_valid, want.evicted_page,
                                     want.fault_total);
                            $display("                 got fault=%0b ev=%0b page=%0d total=%0d",
                                     got.fault, got.evicted_valid, got.evicted_page,
                                     got.fault_total);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Write frame_count once the block has drained.
    task automatic set_frames(input logic [FRAME_CNT_W-1:0] value);
        while (pending_pages.size() > 0 || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        frame_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_pages(input logic [PAGE_IN_W-1:0] pages[$]);
        foreach (pages[k]) begin
            pending_pages.push_back(pages[k]);
        end
    endtask

    initial begin : stimulus
        logic [PAGE_IN_W-1:0] burst[$];
        int                   span;
        logic [PAGE_IN_W-1:0] flip;
        logic [FRAME_CNT_W-1:0] frames;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset frame count of three: extremes of the page field, a hit,
        // then misses that evict the oldest page.
        queue_pages('{4'd0, 4'd15, 4'd0, 4'd7, 4'd9, 4'd15, 4'd0, 4'd5});

        // Frame count above the maximum clamps to eight: fill the row.
        set_frames(4'd15);
        queue_pages('{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12});

        // Lower the frame count with eight pages resident: each miss
        // evicts one and appends one.
        set_frames(4'd2);
        queue_pages('{4'd14, 4'd1, 4'd14});

        // Frame count zero clamps to one.
        set_frames(4'd0);
        queue_pages('{4'd3, 4'd3, 4'd11});

        // Random phases: pages drawn from a random working set so that
        // hits and misses both occur, with some noise.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: frames = 4'd8;
                1: frames = 4'd1;
                2: frames = 4'd9;
                default: frames = FRAME_CNT_W'($urandom_range(0, 15));
            endcase
            set_frames(frames);
            quiet_phase = (ph % 4 == 3);
            span = $urandom_range(1, 16);
            flip = PAGE_IN_W'($urandom_range(0, 15));
            burst = {};
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst.push_back(PAGE_IN_W'($urandom_range(0, 15)));
                end else begin
                    burst.push_back(PAGE_IN_W'($urandom_range(0, span - 1)) ^ flip);
                end
            end
            queue_pages(burst);
        end

        // Drain, then allow the output register to settle.
        while (pending_pages.size() > 0 || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lru_page_replacement_core.sv
dv/tb_lru_page_replacement_core.sv
